// ----- rtl/ccs_pkg.sv -----
// Package for the column compression selector: widths, register map,
// method codes and the end-of-batch snapshot type.
// No dependencies.
`default_nettype none

package ccs_pkg;

  // Width of the stored column value, sign-extended into a 64-bit key
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned WIDTH_W     = 7;
  localparam int unsigned CLASS_W     = 2;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // Register indexes (paddr[2] selects the 32-bit word)
  localparam logic REG_COLUMN_CLASS = 1'b0;
  localparam logic REG_BITPACK_MAX  = 1'b1;

  // Column classes
  localparam logic [CLASS_W-1:0] CLASS_INTEGER = 2'd0;

  // Register reset values
  localparam logic [CLASS_W-1:0] COLUMN_CLASS_RST = CLASS_INTEGER;
  localparam logic [WIDTH_W-1:0] BITPACK_MAX_RST  = 7'd32;

  // Beat kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // Key extremes (keys are values with the sign bit flipped)
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_MIN = {KEY_W{1'b0}};

  typedef enum logic [1:0] {
    METHOD_UNCOMPRESSED = 2'd0,
    METHOD_RLE          = 2'd1,
    METHOD_BITPACK      = 2'd2,
    METHOD_DELTA        = 2'd3
  } method_e;

  // Batch statistics captured when the end beat arrives
  typedef struct packed {
    logic             started;
    logic             all_same;
    logic             non_decreasing;
    logic [KEY_W-1:0] range;
  } snap_t;

endpackage

`default_nettype wire

// ----- rtl/ccs_in_if.sv -----
// Input channel of the column compression selector: one value or end beat.
// No dependencies.
`default_nettype none

interface ccs_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [63:0] value;
  logic        is_null;

  modport source (output valid, output kind, output value, output is_null, input ready);
  modport sink   (input valid, input kind, input value, input is_null, output ready);
endinterface

`default_nettype wire

// ----- rtl/ccs_out_if.sv -----
// Result channel of the column compression selector: one choice per batch.
// Depends on ccs_pkg.
`default_nettype none

interface ccs_out_if;
  logic                           valid;
  logic                           ready;
  ccs_pkg::method_e               method;
  logic [ccs_pkg::WIDTH_W-1:0]    pack_width;

  modport source (output valid, output method, output pack_width, input ready);
  modport sink   (input valid, input method, input pack_width, output ready);
endinterface

`default_nettype wire

// ----- rtl/column_compression_selector.sv -----
// A result beat passes through the end snapshot and the result register after its end beat is accepted.
// Throughput: one beat per cycle, value and end beats alike; a pending result
// blocks input only when a second end beat is already captured behind it.
// Reset (rst_ni low, asynchronous): pipeline empty, batch statistics cleared,
// column_class = 0 and bitpack_max_width = 32. No clearing pass is needed.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if.
`default_nettype none

module column_compression_selector (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  ccs_in_if.sink                           in_i,
  ccs_out_if.source                        out_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [ccs_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire [ccs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ccs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import ccs_pkg::*;

  localparam int unsigned EXT_SHIFT = KEY_W - VALUE_WIDTH;

  // ---------------------------------------------------------------- config
  logic [CLASS_W-1:0] column_class_q;
  logic [WIDTH_W-1:0] bitpack_max_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_class_q <= COLUMN_CLASS_RST;
      bitpack_max_q  <= BITPACK_MAX_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COLUMN_CLASS: column_class_q <= pwdata[CLASS_W-1:0];
        REG_BITPACK_MAX:  bitpack_max_q  <= pwdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_COLUMN_CLASS: prdata[CLASS_W-1:0] = column_class_q;
      REG_BITPACK_MAX:  prdata[WIDTH_W-1:0] = bitpack_max_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  logic snap_v_q, out_v_q, a_v_q;
  logic en;

  // Freeze only when an end beat waits in the snapshot behind a stalled result
  assign en         = !(snap_v_q && out_v_q && !out_o.ready);
  assign in_i.ready = en;

  // ---------------------------------------------------------------- input register
  logic             a_kind_q, a_null_q;
  logic [KEY_W-1:0] a_key_q;
  logic [KEY_W-1:0] ext_val;

  // Sign-extend the low VALUE_WIDTH bits
  assign ext_val = $unsigned($signed(in_i.value <<< EXT_SHIFT) >>> EXT_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_i.valid) begin
      a_kind_q <= in_i.kind;
      a_null_q <= in_i.is_null;
      a_key_q  <= {~ext_val[KEY_W-1], ext_val[KEY_W-2:0]};
    end
  end

  // ---------------------------------------------------------------- batch statistics
  logic             started_q, any_q, same_q, nondec_q;
  logic [KEY_W-1:0] first_q, min_q, max_q, prev_q;
  logic             started_d, any_d, same_d, nondec_d;
  logic [KEY_W-1:0] first_d, min_d, max_d, prev_d;
  logic             a_end;

  assign a_end = a_v_q && (a_kind_q == KIND_END);

  always_comb begin
    started_d = started_q;
    any_d     = any_q;
    same_d    = same_q;
    nondec_d  = nondec_q;
    first_d   = first_q;
    min_d     = min_q;
    max_d     = max_q;
    prev_d    = prev_q;
    if (a_end) begin
      // batch closes: back to reset values
      started_d = 1'b0;
      any_d     = 1'b0;
      same_d    = 1'b1;
      nondec_d  = 1'b1;
      min_d     = KEY_MAX;
      max_d     = KEY_MIN;
      prev_d    = KEY_MIN;
    end else if (a_v_q) begin
      started_d = 1'b1;
      if (!a_null_q) begin
        any_d = 1'b1;
        if (!any_q) first_d = a_key_q;
        else if (a_key_q != first_q) same_d = 1'b0;
        if (a_key_q < min_q)  min_d    = a_key_q;
        if (a_key_q > max_q)  max_d    = a_key_q;
        if (a_key_q < prev_q) nondec_d = 1'b0;
        prev_d = a_key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      any_q     <= 1'b0;
      same_q    <= 1'b1;
      nondec_q  <= 1'b1;
      min_q     <= KEY_MAX;
      max_q     <= KEY_MIN;
      prev_q    <= KEY_MIN;
    end else if (en) begin
      started_q <= started_d;
      any_q     <= any_d;
      same_q    <= same_d;
      nondec_q  <= nondec_d;
      min_q     <= min_d;
      max_q     <= max_d;
      prev_q    <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) first_q <= first_d;
  end

  // ---------------------------------------------------------------- end snapshot
  snap_t snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
    end else if (en) begin
      snap_v_q <= a_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && a_end) begin
      snap_q.started        <= started_q;
      snap_q.all_same       <= same_q;
      snap_q.non_decreasing <= nondec_q;
      snap_q.range          <= max_q - min_q;
    end
  end

  // ---------------------------------------------------------------- decision
  logic [KEY_W:0]     therm;
  logic [WIDTH_W-1:0] width;
  method_e            method_d;
  logic [WIDTH_W-1:0] bw_d;

  // therm[i] set when range >= 2^i; the top set bit gives the width
  always_comb begin
    therm[KEY_W] = 1'b0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      therm[i] = therm[i+1] | snap_q.range[i];
    end
    width = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (therm[i] && !therm[i+1]) width = width | WIDTH_W'(i + 1);
    end
  end

  always_comb begin
    method_d = METHOD_UNCOMPRESSED;
    bw_d     = '0;
    if (snap_q.started && column_class_q == CLASS_INTEGER) begin
      if (snap_q.all_same) begin
        method_d = METHOD_RLE;
      end else if (width <= bitpack_max_q) begin
        method_d = METHOD_BITPACK;
        bw_d     = width;
      end else if (snap_q.non_decreasing) begin
        method_d = METHOD_DELTA;
      end
    end
  end

  // ---------------------------------------------------------------- result register
  logic load_out;
  assign load_out = snap_v_q && (!out_v_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.method     <= method_d;
      out_o.pack_width <= bw_d;
    end
  end

  assign out_o.valid = out_v_q;

  // ---------------------------------------------------------------- assertions
  a_result_from_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(snap_v_q))
    else $error("result beat without a captured end beat");

  a_width_only_bitpack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_o.method != METHOD_BITPACK |-> out_o.pack_width == '0)
    else $error("bit width set for a method other than bit packing");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && a_end |=> !started_q && !any_q)
    else $error("batch state not cleared after end beat");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> min_q <= max_q)
    else $error("running minimum above running maximum");

  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_v_q && !en |=> snap_v_q && $stable(snap_q))
    else $error("captured end beat lost during stall");

endmodule

`default_nettype wire
